/* rtl/core/lebuf_pkg.sv */
// Package for the line edit buffer: key codes, sequencer states, store sizes.
// No dependencies; imported by line_edit_buffer.
`timescale 1ns / 1ps

package lebuf_pkg;

    localparam int STORE_DEPTH       = 64;
    localparam int ADDR_W            = 6;
    localparam int LEN_W             = 7;
    localparam int KEY_W             = 9;
    localparam int CHAR_W            = 8;
    localparam int LINE_CAPACITY_DEF = 64;

    localparam logic [KEY_W-1:0] KEY_ENTER  = 9'd10;
    localparam logic [KEY_W-1:0] KEY_ESCAPE = 9'd27;
    localparam logic [KEY_W-1:0] KEY_BKSP   = 9'd127;
    localparam logic [KEY_W-1:0] KEY_LEFT   = 9'd260;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 9'd261;
    localparam logic [KEY_W-1:0] KEY_HOME   = 9'd262;
    localparam logic [KEY_W-1:0] KEY_DELETE = 9'd330;
    localparam logic [KEY_W-1:0] KEY_END    = 9'd360;

    // Ignored keys: tab, up/down, function keys, insert and page keys.
    localparam logic [KEY_W-1:0] KEY_TAB    = 9'd9;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 9'd258;
    localparam logic [KEY_W-1:0] KEY_UP     = 9'd259;
    localparam logic [KEY_W-1:0] KEY_F_LO   = 9'd265;
    localparam logic [KEY_W-1:0] KEY_F_HI   = 9'd276;
    localparam logic [KEY_W-1:0] KEY_INS    = 9'd331;
    localparam logic [KEY_W-1:0] KEY_PGDN   = 9'd338;
    localparam logic [KEY_W-1:0] KEY_PGUP   = 9'd339;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ROUTE,
        S_SHIFT,
        S_DRAIN,
        S_INSERT,
        S_EMIT
    } t_state;

    function automatic logic key_ignored(input logic [KEY_W-1:0] k);
        logic hit;
        hit = (k == KEY_TAB) || (k == KEY_DOWN) || (k == KEY_UP) ||
              ((k >= KEY_F_LO) && (k <= KEY_F_HI)) ||
              (k == KEY_INS) || (k == KEY_PGDN) || (k == KEY_PGUP);
        return hit;
    endfunction

endpackage

/* rtl/core/line_edit_buffer.sv */
// Line edit buffer top level: key decode, shift sequencer, line store, emitter.
// Depends on lebuf_pkg (key codes, state type, store sizes).
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------------
//  key      | in        | start high, busy low      | i_key_code
//  result   | out       | o_strobe, one cycle each  | o_char_valid o_char_index
//           |           |                           | o_char_value o_line_length
//           |           |                           | o_cursor_position o_keep_focus
//           |           |                           | o_last_of_run
//
//  Steps: a key is decoded in DECODE and ROUTE, then an insert or remove moves one
//  character per cycle (up to 63), with one drain step after any move and one insert
//  step for a new character, then one character is emitted per cycle (at least one);
//  the next item can be accepted in the cycle that shows the last result.
//  The store's one read port sets the pace of a key, since every move and every
//  emitted character is one read through it.
//  Reset clears the length, the cursor and the sequencer; the store is not cleared.
//  Results are pushed out one per cycle and cannot be held off by the receiver.

module line_edit_buffer
    import lebuf_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KEY_W-1:0]    i_key_code,
    output logic                o_strobe,
    output logic                o_char_valid,
    output logic [ADDR_W-1:0]   o_char_index,
    output logic [CHAR_W-1:0]   o_char_value,
    output logic [LEN_W-1:0]    o_line_length,
    output logic [LEN_W-1:0]    o_cursor_position,
    output logic                o_keep_focus,
    output logic                o_last_of_run
);

    localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

    // Sequencer and line state
    t_state              r_state, n_state;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [LEN_W-1:0]    r_count, n_count;
    logic [LEN_W-1:0]    r_cursor, n_cursor;
    logic [ADDR_W-1:0]   r_idx, n_idx;       // read address of the shared port
    logic [ADDR_W-1:0]   r_stop, n_stop;     // last read address of a shift
    logic [ADDR_W-1:0]   r_pos, n_pos;       // insert position
    logic                r_dir_up, n_dir_up; // remove moves down-addressed
    logic                r_do_shift, n_do_shift;
    logic                r_do_ins, n_do_ins;

    // Pending write of a moved character, made in the cycle after its read
    logic                r_wr_pend, n_wr_pend;
    logic [ADDR_W-1:0]   r_wr_addr, n_wr_addr;

    // Result register
    logic                r_o_strobe, n_o_strobe;
    logic                r_o_char_valid, n_o_char_valid;
    logic [ADDR_W-1:0]   r_o_char_index, n_o_char_index;
    logic                r_o_last, n_o_last;

    // Line store with one read port and one write port
    logic [CHAR_W-1:0]   r_mem [STORE_DEPTH];
    logic [CHAR_W-1:0]   r_rd_data;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [CHAR_W-1:0]   w_wdata;

    // Decode helpers
    logic [LEN_W-1:0]    w_cur_m1;
    logic [LEN_W-1:0]    w_cnt_m1;
    logic [LEN_W-1:0]    w_idx_p1;

    assign w_cur_m1 = r_cursor - LEN_W'(1);
    assign w_cnt_m1 = r_count - LEN_W'(1);
    assign w_idx_p1 = {1'b0, r_idx} + LEN_W'(1);

    // Store port: moved characters write from the pending slot, the new key in INSERT
    assign w_we    = r_wr_pend || (r_state == S_INSERT);
    assign w_waddr = (r_state == S_INSERT) ? r_pos : r_wr_addr;
    assign w_wdata = (r_state == S_INSERT) ? r_key[CHAR_W-1:0] : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_idx];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_ROUTE;
            end
            S_ROUTE: begin
                priority if (r_do_shift) begin
                    n_state = S_SHIFT;
                end else if (r_do_ins) begin
                    n_state = S_INSERT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SHIFT: begin
                if (r_idx == r_stop) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = r_do_ins ? S_INSERT : S_EMIT;
            end
            S_INSERT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if ((r_count == '0) || (w_idx_p1 == r_count)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and result outputs
    always_comb begin
        n_key          = r_key;
        n_count        = r_count;
        n_cursor       = r_cursor;
        n_idx          = r_idx;
        n_stop         = r_stop;
        n_pos          = r_pos;
        n_dir_up       = r_dir_up;
        n_do_shift     = r_do_shift;
        n_do_ins       = r_do_ins;
        n_wr_pend      = 1'b0;
        n_wr_addr      = r_wr_addr;
        n_o_strobe     = 1'b0;
        n_o_char_valid = r_o_char_valid;
        n_o_char_index = r_o_char_index;
        n_o_last       = r_o_last;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key = i_key_code;
                end
            end
            S_DECODE: begin
                n_do_shift = 1'b0;
                n_do_ins   = 1'b0;
                n_idx      = '0;
                priority if ((r_key == KEY_ENTER) || (r_key == KEY_ESCAPE)) begin
                    n_count  = '0;
                    n_cursor = '0;
                end else if (r_key == KEY_BKSP) begin
                    // Remove the character before the cursor: pull the tail down
                    if (r_cursor != '0) begin
                        n_cursor   = w_cur_m1;
                        n_count    = w_cnt_m1;
                        n_dir_up   = 1'b1;
                        n_idx      = r_cursor[ADDR_W-1:0];
                        n_stop     = w_cnt_m1[ADDR_W-1:0];
                        n_do_shift = (r_cursor != r_count);
                    end
                end else if (r_key == KEY_LEFT) begin
                    if (r_cursor != '0) begin
                        n_cursor = w_cur_m1;
                    end
                end else if (r_key == KEY_RIGHT) begin
                    if (r_cursor < r_count) begin
                        n_cursor = r_cursor + LEN_W'(1);
                    end
                end else if (r_key == KEY_HOME) begin
                    n_cursor = '0;
                end else if (r_key == KEY_DELETE) begin
                    // Remove the character at the cursor
                    if (r_cursor < r_count) begin
                        n_count    = w_cnt_m1;
                        n_dir_up   = 1'b1;
                        n_idx      = w_cur_m1[ADDR_W-1:0] + ADDR_W'(2);
                        n_stop     = w_cnt_m1[ADDR_W-1:0];
                        n_do_shift = (r_cursor != w_cnt_m1);
                    end
                end else if (r_key == KEY_END) begin
                    n_cursor = r_count;
                end else if (!key_ignored(r_key) && (r_count < CAP)) begin
                    // Insert at the cursor: push the tail up, highest first
                    n_count    = r_count + LEN_W'(1);
                    n_cursor   = r_cursor + LEN_W'(1);
                    n_pos      = r_cursor[ADDR_W-1:0];
                    n_dir_up   = 1'b0;
                    n_idx      = w_cnt_m1[ADDR_W-1:0];
                    n_stop     = r_cursor[ADDR_W-1:0];
                    n_do_shift = (r_cursor != r_count);
                    n_do_ins   = 1'b1;
                end else begin
                    n_count = r_count;
                end
            end
            S_ROUTE: begin
                if (!r_do_shift) begin
                    n_idx = '0;
                end
            end
            S_SHIFT: begin
                // Read one character now; its write lands next cycle
                n_wr_pend = 1'b1;
                n_wr_addr = r_dir_up ? (r_idx - ADDR_W'(1)) : (r_idx + ADDR_W'(1));
                if (r_idx == r_stop) begin
                    n_idx = '0;
                end else begin
                    n_idx = r_dir_up ? (r_idx + ADDR_W'(1)) : (r_idx - ADDR_W'(1));
                end
            end
            S_DRAIN: begin
                n_idx = '0;
            end
            S_INSERT: begin
                n_idx = '0;
            end
            S_EMIT: begin
                n_o_strobe = 1'b1;
                if (r_count == '0) begin
                    n_o_char_valid = 1'b0;
                    n_o_char_index = '0;
                    n_o_last       = 1'b1;
                end else begin
                    n_o_char_valid = 1'b1;
                    n_o_char_index = r_idx;
                    n_o_last       = (w_idx_p1 == r_count);
                    n_idx          = r_idx + ADDR_W'(1);
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_cursor   <= '0;
            r_wr_pend  <= 1'b0;
            r_o_strobe <= 1'b0;
            r_do_shift <= 1'b0;
            r_do_ins   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_cursor   <= n_cursor;
            r_wr_pend  <= n_wr_pend;
            r_o_strobe <= n_o_strobe;
            r_do_shift <= n_do_shift;
            r_do_ins   <= n_do_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key          <= n_key;
        r_idx          <= n_idx;
        r_stop         <= n_stop;
        r_pos          <= n_pos;
        r_dir_up       <= n_dir_up;
        r_wr_addr      <= n_wr_addr;
        r_o_char_valid <= n_o_char_valid;
        r_o_char_index <= n_o_char_index;
        r_o_last       <= n_o_last;
    end

    // Ports: the emitted character comes straight from the registered store read
    assign busy              = (r_state != S_IDLE);
    assign o_strobe          = r_o_strobe;
    assign o_char_valid      = r_o_char_valid;
    assign o_char_index      = r_o_char_valid ? r_o_char_index : '0;
    assign o_char_value      = r_o_char_valid ? r_rd_data : '0;
    assign o_line_length     = r_count;
    assign o_cursor_position = r_cursor;
    assign o_keep_focus      = (r_count != '0);
    assign o_last_of_run     = r_o_last;

    // Checks
    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("cursor beyond line length");

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("line length beyond capacity");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wr_pend && (r_state == S_INSERT)))
        else $error("moved character and new key write in the same cycle");

    a_run_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_strobe && r_o_last) |=> !r_o_strobe)
        else $error("result right after the last of a run");

    a_emit_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_wr_pend)
        else $error("store write still pending while emitting");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for line_edit_buffer: sends key codes, predicts each emitted line.
// Depends on lebuf_pkg (key codes, widths, capacity) and the line_edit_buffer RTL.
`timescale 1ns / 1ps

module tb_top;
    import lebuf_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    // Even at the slowest key, a few hundred keys plus sender gaps stay far below this.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TAIL  = 160;
    localparam int REPORT_CAP   = 40;

    // One emitted character of the line, as seen on the result ports.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] index;
        logic [CHAR_W-1:0] value;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  cursor;
        logic              keep;
        logic              last;
    } t_line_char;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic [KEY_W-1:0]  i_key_code = '0;
    logic              busy;
    logic              o_strobe;
    logic              o_char_valid;
    logic [ADDR_W-1:0] o_char_index;
    logic [CHAR_W-1:0] o_char_value;
    logic [LEN_W-1:0]  o_line_length;
    logic [LEN_W-1:0]  o_cursor_position;
    logic              o_keep_focus;
    logic              o_last_of_run;

    // Shadow copy of the edited line, updated as each key is accepted.
    logic [CHAR_W-1:0] line_chars [STORE_DEPTH];
    int                line_len = 0;
    int                shadow_cursor = 0;

    t_line_char        pending_chars [$];

    int                error_count = 0;
    int                reports_shown = 0;
    int                keys_sent = 0;
    int                chars_checked = 0;
    int                longest_line = 0;
    int                dropped_inserts = 0;
    int                cycle_count = 0;

    line_edit_buffer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_key_code        (i_key_code),
        .o_strobe          (o_strobe),
        .o_char_valid      (o_char_valid),
        .o_char_index      (o_char_index),
        .o_char_value      (o_char_value),
        .o_line_length     (o_line_length),
        .o_cursor_position (o_cursor_position),
        .o_keep_focus      (o_keep_focus),
        .o_last_of_run     (o_last_of_run)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Guard against a hung block: end the run once the cycle budget is spent.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic bit key_is_ignored(input logic [KEY_W-1:0] key);
        return (key == KEY_TAB) || (key == KEY_DOWN) || (key == KEY_UP) ||
               (key >= KEY_F_LO && key <= KEY_F_HI) ||
               (key == KEY_INS) || (key == KEY_PGDN) || (key == KEY_PGUP);
    endfunction

    function automatic bit key_is_command(input logic [KEY_W-1:0] key);
        return (key == KEY_ENTER) || (key == KEY_ESCAPE) || (key == KEY_BKSP) ||
               (key == KEY_LEFT) || (key == KEY_RIGHT) || (key == KEY_HOME) ||
               (key == KEY_DELETE) || (key == KEY_END);
    endfunction

    // Close the gap at pos: every character above it moves down by one.
    function automatic void remove_char(input int pos);
        if (pos >= line_len)
            return;
        for (int j = pos; j + 1 < line_len; j++)
            line_chars[j] = line_chars[j + 1];
        line_len--;
    endfunction

    // Apply one key to the shadow line, then queue the whole line it emits.
    function automatic void edit_line(input logic [KEY_W-1:0] key);
        t_line_char ch;
        case (key)
            KEY_ENTER, KEY_ESCAPE: begin
                line_len      = 0;
                shadow_cursor = 0;
            end
            KEY_BKSP: begin
                if (shadow_cursor > 0) begin
                    shadow_cursor--;
                    remove_char(shadow_cursor);
                end
            end
            KEY_LEFT:   if (shadow_cursor > 0) shadow_cursor--;
            KEY_RIGHT:  if (shadow_cursor < line_len) shadow_cursor++;
            KEY_HOME:   shadow_cursor = 0;
            KEY_DELETE: if (shadow_cursor < line_len) remove_char(shadow_cursor);
            KEY_END:    shadow_cursor = line_len;
            default: begin
                if (!key_is_ignored(key)) begin
                    if (line_len < LINE_CAPACITY_DEF) begin
                        // Open a gap at the cursor and drop the low byte of the code into it.
                        for (int j = line_len; j > shadow_cursor; j--)
                            line_chars[j] = line_chars[j - 1];
                        line_chars[shadow_cursor] = key[CHAR_W-1:0];
                        line_len++;
                        shadow_cursor++;
                    end else begin
                        dropped_inserts++;
                    end
                end
            end
        endcase

        if (line_len > longest_line)
            longest_line = line_len;

        if (line_len == 0) begin
            ch      = '0;
            ch.last = 1'b1;
            pending_chars.push_back(ch);
        end else begin
            for (int j = 0; j < line_len; j++) begin
                ch.valid  = 1'b1;
                ch.index  = ADDR_W'(j);
                ch.value  = line_chars[j];
                ch.length = LEN_W'(line_len);
                ch.cursor = LEN_W'(shadow_cursor);
                ch.keep   = 1'b1;
                ch.last   = (j == line_len - 1);
                pending_chars.push_back(ch);
            end
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            if (reports_shown < REPORT_CAP) begin
                reports_shown++;
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    // Sample results mid-cycle so the compare never races the clock edge.
    always @(negedge i_clk) begin : check_line_chars
        t_line_char want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_chars.size() == 0) begin
                error_count++;
                if (reports_shown < REPORT_CAP) begin
                    reports_shown++;
                    $display("%0t ns: unexpected result, expected none, got index %0d value %0d",
                             $time, o_char_index, o_char_value);
                end
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                check_field("char_valid",      32'(want.valid),  32'(o_char_valid));
                check_field("char_index",      32'(want.index),  32'(o_char_index));
                check_field("char_value",      32'(want.value),  32'(o_char_value));
                check_field("line_length",     32'(want.length), 32'(o_line_length));
                check_field("cursor_position", 32'(want.cursor), 32'(o_cursor_position));
                check_field("keep_focus",      32'(want.keep),   32'(o_keep_focus));
                check_field("last_of_run",     32'(want.last),   32'(o_last_of_run));
            end
        end
    end

    // ---------------------------------------------------------------- sender

    // Enter at a rising edge; return at the edge that accepts the item, with start still high.
    task automatic send_key(input logic [KEY_W-1:0] key);
        start      <= 1'b1;
        i_key_code <= key;
        @(negedge i_clk);
        while (busy !== 1'b0)
            @(negedge i_clk);
        @(posedge i_clk);
        edit_line(key);
        keys_sent++;
    endtask

    // Hold start low for a gap of the given number of clock cycles.
    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off the sender until every queued result has come out.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // A printable or arbitrary code that neither edits nor is ignored: it inserts unless the line is full.
    function automatic logic [KEY_W-1:0] insert_code();
        logic [KEY_W-1:0] code;
        do
            code = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
        while (key_is_command(code) || key_is_ignored(code));
        return code;
    endfunction

    function automatic logic [KEY_W-1:0] ignored_code();
        case ($urandom_range(0, 6))
            0:       return KEY_TAB;
            1:       return KEY_DOWN;
            2:       return KEY_UP;
            3:       return KEY_INS;
            4:       return KEY_PGDN;
            5:       return KEY_PGUP;
            default: return KEY_W'($urandom_range(KEY_F_LO, KEY_F_HI));
        endcase
    endfunction

    // Typing-like mix: mostly inserts and cursor moves, rare clears so lines grow long.
    function automatic logic [KEY_W-1:0] typing_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 42) return insert_code();
        if (pick < 54) return KEY_LEFT;
        if (pick < 61) return KEY_RIGHT;
        if (pick < 65) return KEY_HOME;
        if (pick < 69) return KEY_END;
        if (pick < 79) return KEY_BKSP;
        if (pick < 87) return KEY_DELETE;
        if (pick < 89) return ($urandom_range(0, 1) != 0) ? KEY_ENTER : KEY_ESCAPE;
        if (pick < 93) return ignored_code();
        return KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
    endfunction

    // ---------------------------------------------------------------- tests

    // Every editing and moving key on an empty line: nothing changes, one empty result each.
    task automatic test_empty_line();
        send_key(KEY_BKSP);
        send_key(KEY_LEFT);
        send_key(KEY_DELETE);
        send_key(KEY_RIGHT);
        send_key(KEY_HOME);
        send_key(KEY_END);
        send_key(KEY_TAB);
        drain_results();
    endtask

    // Code extremes, codes above 255 that insert their low byte, edges of the cursor, every
    // ignored key but tab on a non-empty line (function keys at both ends), and both clearing keys.
    task automatic test_edit_keys();
        send_key(9'h000);
        send_key(9'h0FF);
        send_key(9'h1FF);
        send_key(9'h100);
        send_key(9'd300);
        send_key(KEY_RIGHT);
        send_key(KEY_DELETE);
        send_key(KEY_LEFT);
        send_key(KEY_LEFT);
        send_key(KEY_BKSP);
        send_key(KEY_DELETE);
        send_key(KEY_HOME);
        send_key(KEY_BKSP);
        send_key(KEY_LEFT);
        send_key(KEY_END);
        send_key(KEY_DOWN);
        send_key(KEY_UP);
        send_key(KEY_F_LO);
        send_key(KEY_F_HI);
        send_key(KEY_INS);
        send_key(KEY_PGDN);
        send_key(KEY_PGUP);
        send_key(KEY_ENTER);
        send_key(9'h041);
        send_key(KEY_ESCAPE);
        drain_results();
    endtask

    // Fill the line to capacity with random text, then push at both ends of a full line.
    task automatic test_full_line();
        send_key(KEY_ESCAPE);
        while (line_len < LINE_CAPACITY_DEF) begin
            case ($urandom_range(0, 7))
                0:       send_key(KEY_LEFT);
                1:       send_key(KEY_HOME);
                default: send_key(insert_code());
            endcase
            if ($urandom_range(0, 5) == 0)
                pause_sender($urandom_range(1, 20));
        end
        send_key(insert_code());
        send_key(KEY_END);
        send_key(insert_code());
        send_key(KEY_HOME);
        send_key(insert_code());
        send_key(KEY_DELETE);
        send_key(insert_code());
        send_key(KEY_END);
        send_key(KEY_RIGHT);
        send_key(KEY_DELETE);
        send_key(KEY_BKSP);
        send_key(insert_code());
        drain_results();
    endtask

    // Random typing in bursts with random gaps; drain now and then so the sender
    // also restarts from a fully idle block.
    task automatic test_random_typing(input int item_total);
        int burst;
        int since_drain;
        since_drain = 0;
        while (item_total > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > item_total)
                burst = item_total;
            repeat (burst)
                send_key(typing_key());
            item_total  -= burst;
            since_drain += burst;
            if (since_drain >= 60) begin
                drain_results();
                since_drain = 0;
            end else if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 150));
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_empty_line();
        test_edit_keys();
        test_full_line();
        test_random_typing(130);

        // Stop sending, let the last line drain, then watch for stray results.
        drain_results();
        repeat (SETTLE_TAIL) @(posedge i_clk);

        $display("Sent %0d keys and checked %0d emitted characters.", keys_sent, chars_checked);
        $display("Longest line %0d characters; %0d inserts dropped on a full line.",
                 longest_line, dropped_inserts);
        if (error_count == 0 && pending_chars.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* line_edit_buffer.f */
rtl/core/lebuf_pkg.sv
rtl/core/line_edit_buffer.sv
verif/tb_top.sv
